// ===== design/drld_pkg.sv =====
// ----------------------------------------------------------------------------
// drld_pkg
// Shared constants, types and codes of the delta run-length decoder.
// ----------------------------------------------------------------------------
package drld_pkg;

	localparam int STORE_BYTES = 1024;
	localparam int OUT_LANES   = 8;
	localparam int ADDR_W      = $clog2(STORE_BYTES);
	localparam int LANE_W      = $clog2(OUT_LANES);
	localparam int ROWS        = STORE_BYTES / OUT_LANES;
	localparam int ROW_W       = ADDR_W - LANE_W;
	localparam int OFF_W       = ADDR_W + 1;
	localparam int CNT_W       = 4;
	localparam int TAG_W       = 6;
	localparam int WORD_W      = TAG_W + 8;
	localparam int REC_W       = 11;

	localparam logic [TAG_W-1:0] TAG_FIRST = TAG_W'(1);
	localparam logic [TAG_W-1:0] TAG_LAST  = '1;

	localparam logic [REC_W-1:0] REC_LEN_RESET = REC_W'(64);
	localparam logic [OFF_W-1:0] STORE_LIMIT   = OFF_W'(STORE_BYTES);
	localparam logic [OFF_W-1:0] OFF_SAT       = OFF_W'(STORE_BYTES - 1);

	localparam logic [7:0] DESC_END      = 8'h00;
	localparam logic [7:0] DESC_RESERVED = 8'h80;
	localparam logic [6:0] COUNT_MASK    = 7'h7F;

	typedef enum logic [2:0] {
		STAT_DATA     = 3'd0,
		STAT_END_OK   = 3'd1,
		STAT_LEN_ERR  = 3'd2,
		STAT_RESERVED = 3'd3,
		STAT_OVERRUN  = 3'd4
	} status_t;

	typedef logic [OUT_LANES-1:0][7:0] lane_vec_t;

	typedef struct packed {
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic [7:0]        wr_byte;
		logic [TAG_W-1:0]  wr_tag;
		logic              clr_en;
		logic [ROW_W-1:0]  clr_row;
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
	} mem_req_t;

endpackage

// ===== design/drld_ref_mem.sv =====
// ----------------------------------------------------------------------------
// drld_ref_mem
// Reference copy, banked by offset mod lanes, registered read of a window
// starting at any offset. Entries carry an epoch tag; a stale tag reads as zero.
// ----------------------------------------------------------------------------
module drld_ref_mem (
	input  logic                          clk,
	input  drld_pkg::mem_req_t            req,
	input  logic [drld_pkg::TAG_W-1:0]    epoch,
	output drld_pkg::lane_vec_t           lane_data
);

	logic [drld_pkg::LANE_W-1:0] base_q;
	wire  [drld_pkg::OUT_LANES-1:0][drld_pkg::WORD_W-1:0] rd_word;

	for (genvar b = 0; b < drld_pkg::OUT_LANES; b++) begin : g_bank
		logic [drld_pkg::WORD_W-1:0] bank_mem [drld_pkg::ROWS];
		logic [drld_pkg::WORD_W-1:0] rd_q;
		logic [drld_pkg::LANE_W-1:0] rot;
		logic [drld_pkg::ADDR_W-1:0] rd_pos;

		// bank b serves the window lane whose offset is congruent to b
		assign rot    = drld_pkg::LANE_W'(b) - req.rd_addr[drld_pkg::LANE_W-1:0];
		assign rd_pos = req.rd_addr + drld_pkg::ADDR_W'(rot);

		always_ff @(posedge clk) begin
			if (req.clr_en) begin
				bank_mem[req.clr_row] <= '0;
			end else if (req.wr_en &&
			             req.wr_addr[drld_pkg::LANE_W-1:0] == drld_pkg::LANE_W'(b)) begin
				bank_mem[req.wr_addr[drld_pkg::ADDR_W-1:drld_pkg::LANE_W]] <=
					{req.wr_tag, req.wr_byte};
			end
			if (req.rd_en) begin
				rd_q <= bank_mem[rd_pos[drld_pkg::ADDR_W-1:drld_pkg::LANE_W]];
			end
		end

		assign rd_word[b] = rd_q;
	end

	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			base_q <= req.rd_addr[drld_pkg::LANE_W-1:0];
		end
	end

	// rotate banks back into window order, stale tags read as zero
	always_comb begin
		logic [drld_pkg::LANE_W-1:0] idx;
		logic [drld_pkg::WORD_W-1:0] word;
		lane_data = '0;
		for (int i = 0; i < drld_pkg::OUT_LANES; i++) begin
			idx  = base_q + drld_pkg::LANE_W'(i);
			word = rd_word[idx];
			lane_data[i] = (word[drld_pkg::WORD_W-1:8] == epoch) ? word[7:0] : 8'h00;
		end
	end

endmodule

// ===== design/delta_run_length_decoder_core.sv =====
// ----------------------------------------------------------------------------
// delta_run_length_decoder_core
// Rebuilds a record from a delta stream against a stored reference copy.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_ready): one stream byte per transaction, with
//    clear_reference high on a record's first byte to treat the reference
//    as all zeros.
//  - Output channel (out_valid/out_ready): one result per transaction, up to
//    8 reconstructed byte lanes, or a status result. last_of_run marks the
//    final result caused by an input byte.
//  - cfg_wr_en/cfg_wr_data set record_length; write only while idle.
// Flow: an input byte is taken in idle, decoded in the decode state, and
//  in_ready returns once the block is back in idle. A literal byte, an end or
//  a literal descriptor returns to idle from decode. A repeat descriptor is
//  split into chunks of up to 8 bytes; each chunk is one read of the banked
//  reference memory in the read state, then a load of the output register.
// Reset: state clears and the memory tags are swept, one row a cycle over all
//  128 rows, with in_ready low. Tags wrap every 63 clears; the clear that wraps
//  them costs another full sweep before its byte is decoded.
// Stall: a held output register blocks the next result; decode waits.
// ----------------------------------------------------------------------------
module delta_run_length_decoder_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  stream_byte,
	input  logic        clear_reference,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [9:0]  start_offset,
	output logic [3:0]  lane_count,
	output logic [7:0]  lane_0,
	output logic [7:0]  lane_1,
	output logic [7:0]  lane_2,
	output logic [7:0]  lane_3,
	output logic [7:0]  lane_4,
	output logic [7:0]  lane_5,
	output logic [7:0]  lane_6,
	output logic [7:0]  lane_7,
	output logic        last_of_run,
	input  logic        cfg_wr_en,
	input  logic [10:0] cfg_wr_data
);

	typedef enum logic [4:0] {
		S_SWEEP  = 5'b00001,
		S_IDLE   = 5'b00010,
		S_DECODE = 5'b00100,
		S_READ   = 5'b01000,
		S_EMIT   = 5'b10000
	} state_t;

	state_t                          state_q;
	logic [drld_pkg::ROW_W-1:0]      sweep_row_q;
	logic                            pend_q;      // sweep was caused by a clear
	logic [drld_pkg::TAG_W-1:0]      epoch_q;
	logic [drld_pkg::REC_W-1:0]      rec_len_q;
	logic [7:0]                      byte_q;
	logic [drld_pkg::OFF_W-1:0]      off_q;
	logic                            in_lit_q;
	logic [6:0]                      rem_q;       // literal or repeat bytes left

	logic                            out_valid_q;
	drld_pkg::status_t               status_q;
	logic [drld_pkg::ADDR_W-1:0]     start_q;
	logic [drld_pkg::CNT_W-1:0]      count_q;
	drld_pkg::lane_vec_t             lanes_q;
	logic                            last_q;

	drld_pkg::mem_req_t              mem_req;
	drld_pkg::lane_vec_t             mem_lanes;

	logic                            accept;
	logic                            slot_free;
	logic [drld_pkg::OFF_W-1:0]      limit;
	logic [6:0]                      desc_n;
	logic [drld_pkg::OFF_W:0]        run_end;
	logic                            overrun;
	logic [drld_pkg::ADDR_W-1:0]     stat_off;
	logic                            lit_ok;
	logic [drld_pkg::CNT_W-1:0]      chunk;
	logic                            chunk_last;
	drld_pkg::lane_vec_t             chunk_lanes;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;

	// effective limit is the record length capped at the store size
	assign limit   = (drld_pkg::OFF_W'(rec_len_q) > drld_pkg::STORE_LIMIT) ?
		drld_pkg::STORE_LIMIT : drld_pkg::OFF_W'(rec_len_q);
	assign desc_n  = byte_q[6:0] & drld_pkg::COUNT_MASK;
	assign run_end = {1'b0, off_q} + (drld_pkg::OFF_W + 1)'(desc_n);
	assign overrun = run_end > {1'b0, limit};
	assign stat_off = (off_q > drld_pkg::OFF_SAT) ?
		drld_pkg::OFF_SAT[drld_pkg::ADDR_W-1:0] : off_q[drld_pkg::ADDR_W-1:0];
	assign lit_ok  = off_q < limit;

	// repeat chunk: at most one output word of lanes
	assign chunk_last = rem_q <= 7'(drld_pkg::OUT_LANES);
	assign chunk      = chunk_last ? drld_pkg::CNT_W'(rem_q) :
		drld_pkg::CNT_W'(drld_pkg::OUT_LANES);

	always_comb begin
		chunk_lanes = '0;
		for (int i = 0; i < drld_pkg::OUT_LANES; i++) begin
			if (drld_pkg::CNT_W'(i) < chunk) begin
				chunk_lanes[i] = mem_lanes[i];
			end
		end
	end

	always_comb begin
		mem_req         = '0;
		mem_req.wr_en   = (state_q == S_DECODE) && in_lit_q && lit_ok && slot_free;
		mem_req.wr_addr = off_q[drld_pkg::ADDR_W-1:0];
		mem_req.wr_byte = byte_q;
		mem_req.wr_tag  = epoch_q;
		mem_req.clr_en  = (state_q == S_SWEEP);
		mem_req.clr_row = sweep_row_q;
		mem_req.rd_en   = (state_q == S_READ);
		mem_req.rd_addr = off_q[drld_pkg::ADDR_W-1:0];
	end

	drld_ref_mem u_ref_mem (
		.clk       (clk),
		.req       (mem_req),
		.epoch     (epoch_q),
		.lane_data (mem_lanes)
	);

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_len_q <= drld_pkg::REC_LEN_RESET;
		end else if (cfg_wr_en) begin
			rec_len_q <= cfg_wr_data;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_SWEEP;
			sweep_row_q <= '0;
			pend_q      <= 1'b0;
			epoch_q     <= drld_pkg::TAG_FIRST;
			off_q       <= '0;
			in_lit_q    <= 1'b0;
			rem_q       <= '0;
		end else begin
			unique case (state_q)
				S_SWEEP: begin
					sweep_row_q <= sweep_row_q + drld_pkg::ROW_W'(1);
					if (sweep_row_q == '1) begin
						epoch_q <= drld_pkg::TAG_FIRST;
						pend_q  <= 1'b0;
						state_q <= pend_q ? S_DECODE : S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						if (!clear_reference) begin
							state_q <= S_DECODE;
						end else if (epoch_q == drld_pkg::TAG_LAST) begin
							pend_q  <= 1'b1;
							state_q <= S_SWEEP;
						end else begin
							epoch_q <= epoch_q + drld_pkg::TAG_W'(1);
							state_q <= S_DECODE;
						end
					end
				end
				S_DECODE: begin
					if (in_lit_q) begin
						if (slot_free) begin
							state_q <= S_IDLE;
							if (lit_ok) begin
								off_q <= off_q + drld_pkg::OFF_W'(1);
								rem_q <= rem_q - 7'd1;
								if (rem_q == 7'd1) begin
									in_lit_q <= 1'b0;
								end
							end else begin
								off_q    <= '0;
								in_lit_q <= 1'b0;
								rem_q    <= '0;
							end
						end
					end else if (byte_q == drld_pkg::DESC_END ||
					             byte_q == drld_pkg::DESC_RESERVED || overrun) begin
						if (slot_free) begin
							off_q   <= '0;
							rem_q   <= '0;
							state_q <= S_IDLE;
						end
					end else if (byte_q[7]) begin
						in_lit_q <= 1'b1;
						rem_q    <= desc_n;
						state_q  <= S_IDLE;
					end else begin
						rem_q   <= desc_n;
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (slot_free) begin
						off_q   <= off_q + drld_pkg::OFF_W'(chunk);
						rem_q   <= rem_q - 7'(chunk);
						state_q <= chunk_last ? S_IDLE : S_READ;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// input hold
	always_ff @(posedge clk) begin
		if (accept) begin
			byte_q <= stream_byte;
		end
	end

	// output register: literal bytes and status codes load in decode,
	// repeat chunks in emit; a literal descriptor loads nothing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (slot_free) begin
			out_valid_q <= ((state_q == S_DECODE) &&
			                (in_lit_q || byte_q == drld_pkg::DESC_END ||
			                 byte_q == drld_pkg::DESC_RESERVED || overrun)) ||
			               (state_q == S_EMIT);
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free) begin
			if (state_q == S_EMIT) begin
				status_q <= drld_pkg::STAT_DATA;
				start_q  <= off_q[drld_pkg::ADDR_W-1:0];
				count_q  <= chunk;
				lanes_q  <= chunk_lanes;
				last_q   <= chunk_last;
			end else if (state_q == S_DECODE) begin
				last_q <= 1'b1;
				if (in_lit_q && lit_ok) begin
					status_q <= drld_pkg::STAT_DATA;
					start_q  <= off_q[drld_pkg::ADDR_W-1:0];
					count_q  <= drld_pkg::CNT_W'(1);
					lanes_q  <= {{((drld_pkg::OUT_LANES - 1) * 8){1'b0}}, byte_q};
				end else begin
					start_q <= stat_off;
					count_q <= '0;
					lanes_q <= '0;
					if (in_lit_q) begin
						status_q <= drld_pkg::STAT_OVERRUN;
					end else if (byte_q == drld_pkg::DESC_END) begin
						status_q <= (off_q == limit) ? drld_pkg::STAT_END_OK :
							drld_pkg::STAT_LEN_ERR;
					end else if (byte_q == drld_pkg::DESC_RESERVED) begin
						status_q <= drld_pkg::STAT_RESERVED;
					end else begin
						status_q <= drld_pkg::STAT_OVERRUN;
					end
				end
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign start_offset = start_q;
	assign lane_count   = count_q;
	assign lane_0       = lanes_q[0];
	assign lane_1       = lanes_q[1];
	assign lane_2       = lanes_q[2];
	assign lane_3       = lanes_q[3];
	assign lane_4       = lanes_q[4];
	assign lane_5       = lanes_q[5];
	assign lane_6       = lanes_q[6];
	assign lane_7       = lanes_q[7];
	assign last_of_run  = last_q;

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for delta_run_length_decoder_core. Bytes are pushed in
// over the valid/ready input side. Each accepted byte goes through a local
// decoder copy that keeps its own reference store, and the results it
// predicts are queued. Every result transaction is checked field by field
// against the head of that queue. Both sides idle at random, and the output
// side is held off once for a long stretch.
// ----------------------------------------------------------------------------
module tb;

	localparam int CLK_PERIOD    = 10;
	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_ITEMS  = 70;    // per idling mode
	localparam logic [7:0] LITERAL_FLAG = 8'h80;

	// One predicted result transaction.
	typedef struct packed {
		drld_pkg::status_t   st;
		logic [9:0]          off;
		logic [3:0]          cnt;
		drld_pkg::lane_vec_t lanes;
		logic                last;
	} result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  stream_byte = 8'h00;
	logic        clear_reference = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  status;
	logic [9:0]  start_offset;
	logic [3:0]  lane_count;
	logic [7:0]  lane_0, lane_1, lane_2, lane_3, lane_4, lane_5, lane_6, lane_7;
	logic        last_of_run;
	logic        cfg_wr_en = 1'b0;
	logic [10:0] cfg_wr_data = 11'd0;

	// Local decoder state: reference bytes, live bits (cleared by
	// clear_reference), and which entries were ever written since reset.
	logic [7:0]  ref_bytes [drld_pkg::STORE_BYTES];
	bit          ref_live [drld_pkg::STORE_BYTES];
	bit          ever_written [drld_pkg::STORE_BYTES];
	int          wr_off;
	bit          lit_mode;
	int          lit_left;
	logic [10:0] record_len = drld_pkg::REC_LEN_RESET;

	result_t     decoded_q [$];   // predicted results, oldest first

	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	int          hold_req = 0;    // request a long output stall, in cycles
	int          hold_left = 0;
	int          sent_count = 0;
	int          err_cnt = 0;
	int          cycle_cnt = 0;

	delta_run_length_decoder_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.stream_byte    (stream_byte),
		.clear_reference(clear_reference),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.start_offset   (start_offset),
		.lane_count     (lane_count),
		.lane_0         (lane_0),
		.lane_1         (lane_1),
		.lane_2         (lane_2),
		.lane_3         (lane_3),
		.lane_4         (lane_4),
		.lane_5         (lane_5),
		.lane_6         (lane_6),
		.lane_7         (lane_7),
		.last_of_run    (last_of_run),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Watchdog. Covers the reset sweep and the sweeps on tag wrap as well.
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$error("timeout after %0d cycles, %0d results outstanding",
				cycle_cnt, decoded_q.size());
			$display("simulation failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Decoder copy
	// ------------------------------------------------------------------

	// Limit is record_length clamped to the store size.
	function automatic int eff_limit();
		return (record_len > drld_pkg::STORE_BYTES) ? drld_pkg::STORE_BYTES :
			int'(record_len);
	endfunction

	// Consecutive ever-written entries from 'from', at most 'most'.
	function automatic int written_run(input int from, input int most);
		int k;
		k = 0;
		while (k < most && from + k < drld_pkg::STORE_BYTES && ever_written[from + k])
			k++;
		return k;
	endfunction

	// Appends one predicted result at the tail of the queue.
	task automatic expect_result(input result_t r);
		decoded_q.insert(decoded_q.size(), r);
	endtask

	// Status result: offset saturates to 1023, then decoding restarts.
	task automatic emit_status(input drld_pkg::status_t s);
		result_t r;
		r = '0;
		r.st = s;
		r.off = (wr_off > 1023) ? 10'd1023 : 10'(wr_off);
		r.last = 1'b1;
		expect_result(r);
		wr_off = 0;
		lit_mode = 1'b0;
		lit_left = 0;
	endtask

	// Works out the results of one accepted byte and updates the state.
	task automatic decode_byte(input logic [7:0] b, input logic clr);
		int lim, n, done, cnt;
		result_t r;
		lim = eff_limit();
		if (clr)
			foreach (ref_live[i]) ref_live[i] = 1'b0;
		if (lit_mode) begin
			// literal byte; past the limit only if the limit was lowered
			if (wr_off >= lim) begin
				emit_status(drld_pkg::STAT_OVERRUN);
				return;
			end
			ref_bytes[wr_off] = b;
			ref_live[wr_off] = 1'b1;
			ever_written[wr_off] = 1'b1;
			r = '0;
			r.st = drld_pkg::STAT_DATA;
			r.off = 10'(wr_off);
			r.cnt = 4'd1;
			r.lanes[0] = b;
			r.last = 1'b1;
			expect_result(r);
			wr_off++;
			lit_left = (lit_left - 1) & int'(drld_pkg::COUNT_MASK);
			if (lit_left == 0)
				lit_mode = 1'b0;
		end else if (b == drld_pkg::DESC_END) begin
			emit_status((wr_off == lim) ? drld_pkg::STAT_END_OK : drld_pkg::STAT_LEN_ERR);
		end else if (b == drld_pkg::DESC_RESERVED) begin
			emit_status(drld_pkg::STAT_RESERVED);
		end else begin
			n = int'(b[6:0]);
			if (wr_off + n > lim) begin
				emit_status(drld_pkg::STAT_OVERRUN);
			end else if (b[7]) begin
				// literal descriptor: no result of its own
				lit_mode = 1'b1;
				lit_left = n;
			end else begin
				// repeat run, split into chunks of at most OUT_LANES bytes
				done = 0;
				while (done < n) begin
					cnt = n - done;
					if (cnt > drld_pkg::OUT_LANES)
						cnt = drld_pkg::OUT_LANES;
					r = '0;
					r.st = drld_pkg::STAT_DATA;
					r.off = 10'(wr_off + done);
					r.cnt = 4'(cnt);
					for (int i = 0; i < cnt; i++)
						r.lanes[i] = ref_live[wr_off + done + i] ?
							ref_bytes[wr_off + done + i] : 8'h00;
					r.last = (done + cnt == n);
					expect_result(r);
					done += cnt;
				end
				wr_off += n;
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Input side
	// ------------------------------------------------------------------

	// Sends one byte. Valid stays high after acceptance so that a following
	// call can go back to back; anything that waits lowers it first.
	task automatic send_item(input logic [7:0] b, input logic clr);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		stream_byte <= b;
		clear_reference <= clr;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		decode_byte(b, clr);
		sent_count++;
	endtask

	// Waits until every predicted result came out, then lets the block settle.
	task automatic drain();
		in_valid <= 1'b0;
		while (decoded_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Block must be idle here.
	task automatic set_record_length(input logic [10:0] len);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= len;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		record_len = len;
	endtask

	// One well-formed record from the current offset, with a small chance of
	// breaking off with an early end, a reserved code or an overrun.
	task automatic send_record(input logic clr_first);
		int lim, room, avail, n;
		logic c;
		c = clr_first;
		// finish a literal run left open by noise
		while (lit_mode) begin
			send_item(8'($urandom_range(255)), c);
			c = 1'b0;
		end
		lim = eff_limit();
		while (wr_off < lim) begin
			room = lim - wr_off;
			if (room > 127)
				room = 127;
			if ($urandom_range(19) == 0) begin
				case ($urandom_range(2))
					0: send_item(drld_pkg::DESC_END, c);
					1: send_item(drld_pkg::DESC_RESERVED, c);
					default: begin
						if (room < 127) begin
							n = $urandom_range(room + 1, 127);
							send_item(($urandom_range(1) ? LITERAL_FLAG : 8'h00) | 8'(n), c);
						end else begin
							send_item(drld_pkg::DESC_RESERVED, c);
						end
					end
				endcase
				return;
			end
			avail = written_run(wr_off, room);
			if (avail > 0 && $urandom_range(1) == 1) begin
				send_item(8'($urandom_range(1, avail)), c);
			end else begin
				// mostly short literal runs, now and then up to the room left
				if ($urandom_range(3) == 0)
					n = $urandom_range(1, room);
				else
					n = $urandom_range(1, (room < 12) ? room : 12);
				send_item(LITERAL_FLAG | 8'(n), c);
				repeat (n) send_item(8'($urandom_range(255)), 1'b0);
			end
			c = 1'b0;
		end
		send_item(drld_pkg::DESC_END, c);
	endtask

	// Random bytes; a repeat that would read never-written entries is turned
	// into a literal descriptor.
	task automatic send_noise(input int count);
		logic [7:0] b;
		repeat (count) begin
			b = 8'($urandom_range(255));
			if (!lit_mode && b != drld_pkg::DESC_END && !b[7]
					&& wr_off + int'(b) <= eff_limit()
					&& written_run(wr_off, int'(b)) < int'(b))
				b = b | LITERAL_FLAG;
			send_item(b, $urandom_range(7) == 0);
		end
	endtask

	// ------------------------------------------------------------------
	// Output side: check each result transaction, drive ready
	// ------------------------------------------------------------------
	always @(posedge clk) begin : result_check
		result_t             want;
		drld_pkg::lane_vec_t got;
		if (out_valid && out_ready) begin
			got = {lane_7, lane_6, lane_5, lane_4, lane_3, lane_2, lane_1, lane_0};
			if (decoded_q.size() == 0) begin
				$error("result with nothing expected: status %0d, start_offset %0d",
					status, start_offset);
				err_cnt++;
			end else begin
				want = decoded_q.pop_front();
				if (status !== want.st) begin
					$error("status: expected %0d, got %0d", want.st, status);
					err_cnt++;
				end
				if (start_offset !== want.off) begin
					$error("start_offset: expected %0d, got %0d", want.off, start_offset);
					err_cnt++;
				end
				if (lane_count !== want.cnt) begin
					$error("lane_count: expected %0d, got %0d", want.cnt, lane_count);
					err_cnt++;
				end
				for (int i = 0; i < drld_pkg::OUT_LANES; i++)
					if (got[i] !== want.lanes[i]) begin
						$error("lane_%0d: expected %0d, got %0d", i, want.lanes[i], got[i]);
						err_cnt++;
					end
				if (last_of_run !== want.last) begin
					$error("last_of_run: expected %0d, got %0d", want.last, last_of_run);
					err_cnt++;
				end
			end
		end
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Every descriptor kind, field extremes and the error paths.
	task automatic test_directed();
		set_record_length(11'd4);
		// literals with clear, then end exactly at the limit
		send_item(LITERAL_FLAG | 8'd4, 1'b1);
		send_item(8'h00, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(8'h5A, 1'b0);
		send_item(8'hA5, 1'b0);
		send_item(drld_pkg::DESC_END, 1'b0);
		// repeat of what was just written
		send_item(8'd4, 1'b0);
		send_item(drld_pkg::DESC_END, 1'b0);
		// repeat after a clear reads zeros, then literals, end ok
		send_item(8'd2, 1'b1);
		send_item(LITERAL_FLAG | 8'd2, 1'b0);
		send_item(8'h11, 1'b0);
		send_item(8'h22, 1'b0);
		send_item(drld_pkg::DESC_END, 1'b0);
		// reserved code, literal and repeat overruns, short record
		send_item(drld_pkg::DESC_RESERVED, 1'b0);
		send_item(LITERAL_FLAG | 8'd5, 1'b0);
		send_item(8'd5, 1'b0);
		send_item(drld_pkg::DESC_END, 1'b0);
		// limit lowered in the middle of a literal run
		send_item(LITERAL_FLAG | 8'd2, 1'b0);
		send_item(8'h33, 1'b0);
		drain();
		set_record_length(11'd1);
		send_item(8'h44, 1'b0);
		// zero length: immediate end is fine, any data overruns
		drain();
		set_record_length(11'd0);
		send_item(drld_pkg::DESC_END, 1'b0);
		send_item(LITERAL_FLAG | 8'd1, 1'b0);
		drain();
	endtask

	// Longest literal run, then the longest repeat over it.
	task automatic test_long_runs();
		set_record_length(11'd1024);
		send_item(LITERAL_FLAG | 8'(drld_pkg::COUNT_MASK), 1'b1);
		repeat (127) send_item(8'($urandom_range(255)), 1'b0);
		send_item(drld_pkg::DESC_END, 1'b0);
		send_item(8'(drld_pkg::COUNT_MASK), 1'b0);    // 16 result transactions
		send_item(drld_pkg::DESC_END, 1'b0);
		drain();
	endtask

	// Output held off while input keeps coming; block must stall its input.
	task automatic test_backpressure();
		set_record_length(11'd48);
		hold_req = 400;
		send_record(1'b1);
		send_record(1'b0);
		drain();
	endtask

	// Mostly well-formed records, some noise, record length changed now and then.
	task automatic test_random(input int s_pct, input int r_pct, input int n_items);
		int first;
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		first = sent_count;
		while (sent_count - first < n_items) begin
			if ($urandom_range(3) == 0) begin
				drain();
				case ($urandom_range(9))
					0: set_record_length(11'd1);
					1: set_record_length(11'($urandom_range(64, 128)));
					default: set_record_length(11'($urandom_range(2, 48)));
				endcase
			end
			if ($urandom_range(5) == 0)
				send_noise($urandom_range(1, 4));
			send_record($urandom_range(2) == 0);
		end
		drain();
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// sender mostly busy, receiver mostly stalled
		send_idle_pct = 16;
		recv_idle_pct = 79;
		test_directed();
		test_random(16, 79, RANDOM_ITEMS);

		// the other way round
		test_random(79, 16, RANDOM_ITEMS);

		// no idling at all
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_long_runs();
		test_backpressure();
		test_random(0, 0, RANDOM_ITEMS);

		drain();
		if (err_cnt == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
